/* hdl/assert_macros.svh */
// Assertion macros for the checker module aech_chk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define AECH_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("aech assertion failed");

// Next-cycle implication, disabled during reset.
`define AECH_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("aech assertion failed");

`endif

/* hdl/aech_pkg.sv */
// ----------------------------------------------------------------------------
// aech_pkg
// Types and constants of the angular energy-cut histogram.
// ----------------------------------------------------------------------------
`default_nettype none

package aech_pkg;

  localparam int CORDIC_STEPS = 17;
  localparam int CW           = 35;   // CORDIC x/y width
  localparam int ZW           = 27;   // CORDIC angle accumulator, Q16 degrees
  localparam int DEN_W        = 49;   // divisor width (span * total)
  localparam int DIV_W        = 40;   // max quotient bits per division
  localparam int CNT_W        = 6;
  localparam int CENTER_BITS  = 17;   // quotient bits of the bin-center divide

  localparam logic signed [ZW-1:0] HALF_TURN   = 27'sd11796480;
  localparam logic signed [ZW-1:0] ROUND_HALF  = 27'sd128;
  localparam logic signed [ZW-1:0] ZLIMIT      = 27'sd46080;
  localparam logic signed [16:0]   ANGLE_LIMIT = 17'sd46080;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SQ_X, ST_SQ_Y, ST_SQ_Z, ST_SQ_T, ST_LIM,
    ST_ROT, ST_ANG, ST_SEL, ST_KLOAD, ST_KDIV, ST_HRD, ST_HWR,
    ST_RBIN, ST_CLOAD, ST_CDIV, ST_DA, ST_DB, ST_DC, ST_DD, ST_DE, ST_DDIV,
    ST_EMIT
  } state_t;

  typedef enum logic [2:0] {
    REG_THETA_MIN,
    REG_THETA_MAX,
    REG_BIN_COUNT,
    REG_ENERGY_THR,
    REG_WEIGHT,
    REG_COUNT_MODE
  } reg_idx_t;

  typedef enum logic {
    OP_SAMPLE,
    OP_FINISH
  } opcode_t;

  // atan(2^-i) in Q16 degrees, rounded
  function automatic logic [24:0] atan_q16(input logic [4:0] i);
    logic [24:0] v;
    unique case (i)
      5'd0:    v = 25'd2949120;
      5'd1:    v = 25'd1740967;
      5'd2:    v = 25'd919879;
      5'd3:    v = 25'd466945;
      5'd4:    v = 25'd234379;
      5'd5:    v = 25'd117304;
      5'd6:    v = 25'd58666;
      5'd7:    v = 25'd29335;
      5'd8:    v = 25'd14668;
      5'd9:    v = 25'd7334;
      5'd10:   v = 25'd3667;
      5'd11:   v = 25'd1833;
      5'd12:   v = 25'd917;
      5'd13:   v = 25'd458;
      5'd14:   v = 25'd229;
      5'd15:   v = 25'd115;
      5'd16:   v = 25'd57;
      default: v = 25'd0;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] abs32(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

endpackage

`default_nettype wire

/* hdl/aech_ram.sv */
// ----------------------------------------------------------------------------
// aech_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module aech_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                         wdata,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

/* hdl/angular_energy_cut_histogram.sv */
// ----------------------------------------------------------------------------
// angular_energy_cut_histogram
// Angular histogram of particle momenta with a kinetic-energy cut; CORDIC
// atan2, one shared multiplier and one shared restoring divider.
// ----------------------------------------------------------------------------
// channel   handshake                  payload
// input     start / busy               opcode, mom_x, mom_y, mom_z
// result    result_valid (strobe)      bin_center, bin_hits, bin_density,
//                                      last_bin
// config    cfg_valid / cfg_ready      cfg_index, cfg_data
//
// Sample: the squares on the shared multiplier, the 17-step CORDIC loop and,
//   for a selected sample, the bin-index divide (one quotient bit per cycle).
// Finish: each bin in use runs the 17-bit center divide and the 40-bit density
//   divide; the density divide is skipped when the density is 0 or saturated.
// Reset is synchronous; it restores the configuration and control registers and empties the store.
// Results are one-cycle strobes; the receiver cannot stall. cfg_ready is
// always high.
`default_nettype none

module angular_energy_cut_histogram
  import aech_pkg::*;
#(
  parameter int MAX_BINS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               opcode,
  input  logic signed [31:0] mom_x,
  input  logic signed [31:0] mom_y,
  input  logic signed [31:0] mom_z,
  output logic               result_valid,
  output logic signed [16:0] bin_center,
  output logic [31:0]        bin_hits,
  output logic [39:0]        bin_density,
  output logic               last_bin,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int IDX_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;

  state_t state, state_next;

  // configuration
  logic signed [16:0] theta_min, theta_max;
  logic [6:0]         bin_count;
  logic [30:0]        energy_threshold;
  logic [31:0]        particle_weight;
  logic               count_mode;

  // sample path
  logic [31:0]          mag_x, mag_y, mag_z;
  logic signed [CW-1:0] cx, cy;
  logic signed [ZW-1:0] cz;
  logic                 y_zero, x_neg, e_pass;
  logic [4:0]           rot_step;
  logic signed [16:0]   angle;

  // shared multiplier and accumulators
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_q, acc;
  logic [48:0] acc2;

  // shared divider
  logic [DEN_W-1:0] div_rem, div_den;
  logic [DIV_W-1:0] div_lo, div_q;
  logic [CNT_W-1:0] div_cnt;
  logic [DEN_W:0]   div_trial, div_diff;
  logic             div_ge;

  // readout
  logic [IDX_W-1:0]   bin_k;
  logic [31:0]        hits, total;
  logic signed [16:0] center;
  logic               d_zero, d_ovf, d_sat, emit_last;
  logic [MAX_BINS-1:0] hit_valid;

  // store
  logic             ram_we;
  logic [IDX_W-1:0] ram_addr;
  logic [31:0]      ram_wdata, ram_rdata, cur_hits;

  // derived
  logic signed [17:0] span, off;
  logic               span_pos, in_win, cy_pos;
  logic [16:0]        span_u;
  logic [6:0]         n_bins;
  logic signed [CW-1:0] sx, sy;
  logic signed [ZW-1:0] atan_ext, zsum, zr;
  logic signed [16:0] angle_new;
  logic [71:0]        pn;
  logic [23:0]        knum;

  assign cfg_ready = 1'b1;
  assign busy      = (state != ST_IDLE);

  assign span     = 18'(theta_max) - 18'(theta_min);
  assign span_pos = (span > 18'sd0);
  assign span_u   = span[16:0];
  assign off      = 18'(angle) - 18'(theta_min);
  assign in_win   = (angle >= theta_min) && (angle < theta_max);

  always_comb begin
    if (bin_count == 7'd0) begin
      n_bins = 7'd1;
    end else if (bin_count > 7'(MAX_BINS)) begin
      n_bins = 7'(MAX_BINS);
    end else begin
      n_bins = bin_count;
    end
  end

  assign emit_last = (7'(bin_k) == (n_bins - 7'd1));

  // CORDIC step
  assign cy_pos   = (cy > 0);
  assign sx       = cx >>> rot_step;
  assign sy       = cy >>> rot_step;
  assign atan_ext = $signed(ZW'(atan_q16(rot_step)));
  assign zsum     = cz + ROUND_HALF;
  assign zr       = zsum >>> 8;

  always_comb begin
    if (y_zero) begin
      angle_new = x_neg ? ANGLE_LIMIT : 17'sd0;
    end else if (zr > ZLIMIT) begin
      angle_new = ANGLE_LIMIT;
    end else if (zr < -ZLIMIT) begin
      angle_new = -ANGLE_LIMIT;
    end else begin
      angle_new = 17'(zr);
    end
  end

  // divider step: one quotient bit per cycle
  assign div_trial = {div_rem, div_lo[DIV_W-1]};
  assign div_ge    = (div_trial >= {1'b0, div_den});
  assign div_diff  = div_trial - {1'b0, div_den};

  assign pn    = {mul_q[39:0], 32'b0} + {33'b0, acc2[38:0]};
  assign d_sat = d_ovf || (DEN_W'(acc[63:40]) >= div_den);
  assign knum  = mul_q[23:0];

  assign cur_hits  = hit_valid[ram_addr] ? ram_rdata : 32'd0;
  assign ram_wdata = (cur_hits == 32'hFFFF_FFFF) ? cur_hits : cur_hits + 32'd1;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = (opcode_t'(opcode) == OP_FINISH) ? ST_RBIN : ST_SQ_X;
        end
      end
      ST_SQ_X:  state_next = ST_SQ_Y;
      ST_SQ_Y:  state_next = ST_SQ_Z;
      ST_SQ_Z:  state_next = ST_SQ_T;
      ST_SQ_T:  state_next = ST_LIM;
      ST_LIM:   state_next = ST_ROT;
      ST_ROT:   state_next = (rot_step == 5'(CORDIC_STEPS - 1)) ? ST_ANG : ST_ROT;
      ST_ANG:   state_next = ST_SEL;
      ST_SEL:   state_next = (e_pass && in_win) ? ST_KLOAD : ST_IDLE;
      ST_KLOAD: state_next = ST_KDIV;
      ST_KDIV:  state_next = (div_cnt == CNT_W'(1)) ? ST_HRD : ST_KDIV;
      ST_HRD:   state_next = ST_HWR;
      ST_HWR:   state_next = ST_IDLE;
      ST_RBIN:  state_next = ST_CLOAD;
      ST_CLOAD: state_next = ST_CDIV;
      ST_CDIV:  state_next = (div_cnt == CNT_W'(1)) ? ST_DA : ST_CDIV;
      ST_DA:    state_next = ST_DB;
      ST_DB:    state_next = ST_DC;
      ST_DC:    state_next = ST_DD;
      ST_DD:    state_next = ST_DE;
      ST_DE:    state_next = (d_zero || d_sat) ? ST_EMIT : ST_DDIV;
      ST_DDIV:  state_next = (div_cnt == CNT_W'(1)) ? ST_EMIT : ST_DDIV;
      ST_EMIT:  state_next = emit_last ? ST_IDLE : ST_RBIN;
      default:  state_next = ST_IDLE;
    endcase
  end

  // control outputs: multiplier operands and store port
  always_comb begin
    mul_a    = 32'd0;
    mul_b    = 32'd0;
    ram_we   = 1'b0;
    ram_addr = bin_k;
    unique case (state)
      ST_SQ_X: begin
        mul_a = mag_x;
        mul_b = mag_x;
      end
      ST_SQ_Y: begin
        mul_a = mag_y;
        mul_b = mag_y;
      end
      ST_SQ_Z: begin
        mul_a = mag_z;
        mul_b = mag_z;
      end
      ST_SQ_T: begin
        mul_a = 32'(energy_threshold);
        mul_b = 32'(energy_threshold);
      end
      ST_SEL: begin
        mul_a = 32'(off[16:0]);
        mul_b = 32'(n_bins);
      end
      ST_HRD: begin
        ram_addr = div_q[IDX_W-1:0];
      end
      ST_HWR: begin
        ram_addr = div_q[IDX_W-1:0];
        ram_we   = 1'b1;
      end
      ST_RBIN: begin
        mul_a = 32'(span_u);
        mul_b = 32'({bin_k, 1'b1});
      end
      ST_DA: begin
        mul_a = hits;
        mul_b = count_mode ? particle_weight : 32'(n_bins);
      end
      ST_DB: begin
        mul_a = count_mode ? mul_q[31:0] : 32'(span_u);
        mul_b = count_mode ? 32'(n_bins) : total;
      end
      ST_DC: begin
        mul_a = acc[63:32];
        mul_b = 32'(n_bins);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      theta_min        <= -ANGLE_LIMIT;
      theta_max        <= ANGLE_LIMIT;
      bin_count        <= 7'd64;
      energy_threshold <= 31'd0;
      particle_weight  <= 32'd65536;
      count_mode       <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_THETA_MIN:  theta_min        <= $signed(cfg_data[16:0]);
        REG_THETA_MAX:  theta_max        <= $signed(cfg_data[16:0]);
        REG_BIN_COUNT:  bin_count        <= cfg_data[6:0];
        REG_ENERGY_THR: energy_threshold <= cfg_data[30:0];
        REG_WEIGHT:     particle_weight  <= cfg_data;
        REG_COUNT_MODE: count_mode       <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // store state and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_valid    <= '0;
      total        <= 32'd0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= (state == ST_EMIT);
      if (state == ST_HWR) begin
        hit_valid[ram_addr] <= 1'b1;
        if (total != 32'hFFFF_FFFF) begin
          total <= total + 32'd1;
        end
      end
      if (state == ST_EMIT) begin
        if (emit_last) begin
          hit_valid <= '0;
          total     <= 32'd0;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    mul_q <= mul_a * mul_b;
    unique case (state)
      ST_IDLE: begin
        mag_x    <= abs32(mom_x);
        mag_y    <= abs32(mom_y);
        mag_z    <= abs32(mom_z);
        x_neg    <= mom_x[31];
        y_zero   <= (mom_y == 32'sd0);
        cx       <= mom_x[31] ? -CW'(mom_x) : CW'(mom_x);
        cy       <= mom_x[31] ? -CW'(mom_y) : CW'(mom_y);
        cz       <= mom_x[31] ? ((mom_y > 32'sd0) ? HALF_TURN : -HALF_TURN) : '0;
        rot_step <= 5'd0;
        bin_k    <= '0;
      end
      ST_SQ_Y: acc <= mul_q;
      ST_SQ_Z: acc <= acc + mul_q;
      ST_SQ_T: acc <= acc + mul_q;
      ST_LIM:  e_pass <= acc > (mul_q + {16'b0, energy_threshold, 17'b0});
      ST_ROT: begin
        if (cy_pos) begin
          cx <= cx + sy;
          cy <= cy - sx;
          cz <= cz + atan_ext;
        end else begin
          cx <= cx - sy;
          cy <= cy + sx;
          cz <= cz - atan_ext;
        end
        rot_step <= rot_step + 5'd1;
      end
      ST_ANG: angle <= angle_new;
      ST_KLOAD: begin
        // quotient is below MAX_BINS, so the top bits seed the remainder
        div_rem <= DEN_W'(knum >> IDX_W);
        div_lo  <= DIV_W'(knum) << (DIV_W - IDX_W);
        div_q   <= '0;
        div_cnt <= CNT_W'(IDX_W);
        div_den <= DEN_W'(span_u);
      end
      ST_CLOAD: begin
        hits    <= hit_valid[ram_addr] ? ram_rdata : 32'd0;
        div_rem <= DEN_W'(knum >> CENTER_BITS);
        div_lo  <= DIV_W'(knum) << (DIV_W - CENTER_BITS);
        div_q   <= '0;
        div_cnt <= CNT_W'(CENTER_BITS);
        div_den <= DEN_W'({n_bins, 1'b0});
      end
      ST_KDIV, ST_CDIV, ST_DDIV: begin
        div_rem <= div_ge ? div_diff[DEN_W-1:0] : div_trial[DEN_W-1:0];
        div_lo  <= div_lo << 1;
        div_q   <= {div_q[DIV_W-2:0], div_ge};
        div_cnt <= div_cnt - CNT_W'(1);
      end
      ST_DA: begin
        center <= span_pos ? $signed(theta_min + $signed(div_q[16:0])) : theta_min;
      end
      ST_DB: acc  <= mul_q;
      ST_DC: acc2 <= mul_q[48:0];
      ST_DD: begin
        if (count_mode) begin
          acc     <= {pn[55:0], 8'b0};
          div_den <= DEN_W'(span_u);
          d_ovf   <= |pn[71:56];
          d_zero  <= !span_pos;
        end else begin
          acc     <= {1'b0, acc[38:0], 24'b0};
          div_den <= acc2;
          d_ovf   <= 1'b0;
          d_zero  <= !span_pos || (acc2 == 49'd0);
        end
      end
      ST_DE: begin
        if (d_zero) begin
          div_q <= '0;
        end else if (d_sat) begin
          div_q <= '1;
        end else begin
          div_rem <= DEN_W'(acc[63:40]);
          div_lo  <= acc[39:0];
          div_q   <= '0;
          div_cnt <= CNT_W'(DIV_W);
        end
      end
      ST_EMIT: begin
        bin_center  <= center;
        bin_hits    <= hits;
        bin_density <= div_q;
        last_bin    <= emit_last;
        bin_k       <= bin_k + IDX_W'(1);
      end
      default: begin
      end
    endcase
  end

  aech_ram #(
    .WIDTH (32),
    .DEPTH (MAX_BINS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire

/* hdl/aech_chk.sv */
// ----------------------------------------------------------------------------
// aech_chk
// Port-level checks on the histogram's command and result timing.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module aech_chk (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic result_valid,
  input logic last_bin
);

  // an accepted command always occupies the block
  `AECH_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy)
  // beats never come back to back
  `AECH_ASSERT_NEXT(a_beat_single, clk, rst, result_valid, !result_valid)
  // readout still running until the last bin
  `AECH_ASSERT_NOW(a_mid_readout, clk, rst, result_valid && !last_bin, busy)
  // last bin ends the readout
  `AECH_ASSERT_NOW(a_last_idle, clk, rst, result_valid && last_bin, !busy)

endmodule

bind angular_energy_cut_histogram aech_chk u_aech_chk (.*);

`default_nettype wire
